/* hdl/pldr_pkg.sv */
// Package for the sound lump decoder and resampler.
// Holds the shared types, status codes and constants; no dependencies.
package pldr_pkg;

    // Configuration and field widths
    localparam int RATE_W          = 17;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int LENGTH_BITS_MAX = 32;
    localparam int MAX_BURST_DEF   = 64;
    localparam int FL_MAX_W        = LENGTH_BITS_MAX + RATE_W;
    localparam int QUEUE_DEPTH     = 4;

    // Header layout and decode constants
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd48000;
    localparam logic [7:0]  HDR_FORMAT  = 8'h03;
    localparam int          HDR_LEN     = 8;
    localparam int          SAMPLE_OFS  = 24;
    localparam logic [31:0] COUNT_MIN   = 32'd48;
    localparam logic [31:0] COUNT_BIAS  = 32'd32;
    localparam logic [7:0]  SAMPLE_BIAS = 8'h80;

    // Result status codes
    localparam logic [2:0] ST_FRAME      = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_COUNT  = 3'd2;
    localparam logic [2:0] ST_NO_FRAMES  = 3'd3;
    localparam logic [2:0] ST_RATE_LOW   = 3'd4;

    typedef enum logic [1:0] {
        F_RUN,
        F_CHK1,
        F_CHK2,
        F_CHK3
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_BURST
    } t_back_state;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_SAMPLE,
        CMD_ERROR
    } t_cmd_kind;

    // Command from the byte parser to the frame generator
    typedef struct packed {
        t_cmd_kind             kind;
        logic [2:0]            code;
        logic [7:0]            sample;
        logic [15:0]           src_rate;
        logic [RATE_W-1:0]     out_rate;
        logic [FL_MAX_W-1:0]   frame_limit;
    } t_cmd;

endpackage

/* hdl/pcm_lump_decode_resample.sv */
// Top level of the sound lump decoder and nearest-neighbor resampler.
// Depends on pldr_pkg, pldr_front, pldr_queue and pldr_back.
//
// Bytes of an 8-bit mono sound lump enter on the slave stream, with tuser
// marking the first byte and the lump length taken from that byte. After
// the eighth byte the header is checked in F_CHK1, F_CHK2 and F_CHK3 (count
// bounds, source rate, a registered count-by-rate multiply); the input stalls
// meanwhile. A header fault gives one result with tlast set and the fault
// code in tuser. Otherwise each sample byte is queued and the frame
// generator emits, one per cycle while the output is ready, every output
// frame that maps onto it as signed 16-bit samples on both channels, tlast
// on the final frame. The generator takes each sample command in B_IDLE
// and emits its frames in B_BURST; header and filler bytes are taken
// while the four-entry command queue has room. output_rate is latched
// when a header completes and applies to the next lump when written
// later.
module pcm_lump_decode_resample import pldr_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,   // output_rate
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,    // data_byte[7:0], lump_length[31:8]
    input  logic              s_axis_tuser,    // first_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,    // left_sample[15:0], right_sample[31:16]
    output logic              m_axis_tlast,    // last_frame
    output logic [2:0]        m_axis_tuser     // status
);

    logic        push, full, qvalid, pop;
    t_cmd        cmd_in, cmd_out;
    logic [15:0] sample;

    pldr_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .MAX_BURST   (MAX_BURST)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_tdata       (s_axis_tdata),
        .i_tuser       (s_axis_tuser),
        .o_push        (push),
        .o_cmd         (cmd_in),
        .i_full        (full)
    );

    pldr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .o_valid (qvalid),
        .o_cmd   (cmd_out),
        .i_pop   (pop)
    );

    pldr_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .MAX_BURST   (MAX_BURST)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_cmd    (cmd_out),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_sample (sample),
        .o_last   (m_axis_tlast),
        .o_status (m_axis_tuser)
    );

    // Both channels carry the same sample
    assign m_axis_tdata = {sample, sample};

endmodule

/* hdl/pldr_front.sv */
// Byte parser: takes lump bytes, checks the header and issues commands.
// Depends on pldr_pkg; feeds pldr_queue.
module pldr_front import pldr_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [31:0]       i_tdata,    // data_byte[7:0], lump_length[31:8]
    input  logic              i_tuser,    // first_byte
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_full
);

    localparam int LB      = LENGTH_BITS;
    localparam int PROD_W  = LB + RATE_W;
    localparam int BURST_W = 16 + $clog2(MAX_BURST + 1);

    t_front_state      r_state, n_state;
    logic [LB-1:0]     r_pos, n_pos;
    logic [LB-1:0]     r_len, n_len;
    logic              r_active, n_active;
    logic [7:0]        r_hdr [HDR_LEN];
    logic [2:0]        r_code;
    logic [15:0]       r_src;
    logic [RATE_W-1:0] r_rate;
    logic [LB-1:0]     r_n;
    logic [PROD_W-1:0] r_prod;
    logic [RATE_W-1:0] r_cfg_rate;

    logic              in_acc;
    logic              hdr_wr;
    logic [LB-1:0]     pos_eff;
    logic [LB-1:0]     len_eff;
    logic [LB-1:0]     len_in;
    logic              live;
    logic [7:0]        in_byte;
    logic [15:0]       hdr_r;
    logic [31:0]       hdr_c;
    logic [2:0]        chk_code;

    assign in_byte = i_tdata[7:0];
    assign len_in  = LB'(i_tdata[31:8]);
    assign o_tready = (r_state == F_RUN) && !i_full;
    assign in_acc   = i_tvalid && o_tready;
    assign pos_eff  = i_tuser ? '0 : r_pos;
    assign len_eff  = i_tuser ? len_in : r_len;
    assign live     = i_tuser || r_active;
    assign hdr_r    = {r_hdr[3], r_hdr[2]};
    assign hdr_c    = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};

    // Header checks in priority order
    always_comb begin
        priority if (r_hdr[0] != HDR_FORMAT || r_hdr[1] != 8'h00) begin
            chk_code = ST_BAD_HEADER;
        end else if ({1'b0, hdr_c} > (33'(r_len) - 33'(HDR_LEN)) || hdr_c <= COUNT_MIN) begin
            chk_code = ST_BAD_COUNT;
        end else if (hdr_r == 16'd0) begin
            chk_code = ST_NO_FRAMES;
        end else if ((BURST_W'(hdr_r) * BURST_W'(MAX_BURST)) < BURST_W'(r_cfg_rate)) begin
            chk_code = ST_RATE_LOW;
        end else begin
            chk_code = ST_FRAME;
        end
    end

    // Next state and command issue
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_len    = r_len;
        n_active = r_active;
        hdr_wr   = 1'b0;
        o_push   = 1'b0;
        o_cmd             = '0;
        o_cmd.kind        = CMD_SAMPLE;
        o_cmd.sample      = in_byte;
        o_cmd.src_rate    = r_src;
        o_cmd.out_rate    = r_rate;
        o_cmd.frame_limit = FL_MAX_W'(r_prod);
        unique case (r_state)
            F_RUN: begin
                if (in_acc) begin
                    if (i_tuser) begin
                        n_len    = len_in;
                        n_pos    = '0;
                        n_active = 1'b1;
                    end
                    if (i_tuser && len_in < LB'(HDR_LEN)) begin
                        // lump too short to hold a header
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.code = ST_BAD_HEADER;
                        n_active   = 1'b0;
                    end else if (live && pos_eff < len_eff) begin
                        n_pos = pos_eff + 1'b1;
                        if (pos_eff < LB'(HDR_LEN)) begin
                            hdr_wr = 1'b1;
                            if (pos_eff == LB'(HDR_LEN - 1)) begin
                                n_state = F_CHK1;
                            end
                        end else if (pos_eff >= LB'(SAMPLE_OFS) &&
                                     (pos_eff - LB'(SAMPLE_OFS)) < r_n) begin
                            o_push = 1'b1;
                        end
                    end
                end
            end
            F_CHK1: begin
                n_state = F_CHK2;
            end
            F_CHK2: begin
                n_state = F_CHK3;
            end
            F_CHK3: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_RUN;
                    if (r_code != ST_FRAME) begin
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.code = r_code;
                        n_active   = 1'b0;
                    end else if (r_prod < PROD_W'(r_src)) begin
                        o_cmd.kind = CMD_ERROR;
                        o_cmd.code = ST_NO_FRAMES;
                        n_active   = 1'b0;
                    end else begin
                        o_cmd.kind = CMD_START;
                    end
                end
            end
            default: begin
                n_state = F_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_RUN;
            r_pos      <= '0;
            r_len      <= '0;
            r_active   <= 1'b0;
            r_cfg_rate <= RATE_RESET;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_active <= n_active;
            if (i_cfg_wr_en) begin
                r_cfg_rate <= i_cfg_wr_data;
            end
        end
    end

    // Header bytes and check pipeline
    always_ff @(posedge i_clk) begin
        if (hdr_wr) begin
            r_hdr[pos_eff[2:0]] <= in_byte;
        end
        if (r_state == F_CHK1) begin
            r_code <= chk_code;
            r_src  <= hdr_r;
            r_rate <= r_cfg_rate;
            r_n    <= LB'(hdr_c - COUNT_BIAS);
        end
        if (r_state == F_CHK2) begin
            r_prod <= PROD_W'(r_n) * PROD_W'(r_rate);
        end
    end

endmodule

/* hdl/pldr_queue.sv */
// Short command queue between the byte parser and the frame generator.
// Depends on pldr_pkg for the command type.
module pldr_queue import pldr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* hdl/pldr_back.sv */
// Frame generator: turns queued commands into output frames and errors.
// Depends on pldr_pkg; fed by pldr_queue, drives the output register.
module pldr_back import pldr_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_qvalid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_sample,
    output logic        o_last,
    output logic [2:0]  o_status
);

    localparam int FL_W  = LENGTH_BITS + RATE_W;
    localparam int B_W   = FL_W + 1;
    localparam int CNT_W = $clog2(MAX_BURST + 1);

    t_back_state       r_state, n_state;
    logic              r_active, n_active;
    logic [15:0]       r_src, n_src;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic [FL_W-1:0]   r_fl, n_fl;
    logic [B_W-1:0]    r_fb, n_fb;
    logic [B_W-1:0]    r_fb1, n_fb1;
    logic [B_W-1:0]    r_fb2, n_fb2;
    logic [B_W-1:0]    r_sb, n_sb;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]       r_v, n_v;

    logic              r_ovalid;
    logic [15:0]       r_osample;
    logic              r_olast;
    logic [2:0]        r_ostatus;

    logic              out_free;
    logic              load;
    logic [15:0]       ld_sample;
    logic              ld_last;
    logic [2:0]        ld_status;
    logic              frame_ok;
    logic              frame_emit;
    logic              emit_last;

    assign out_free  = !r_ovalid || i_tready;
    assign emit_last = (r_fb2 > B_W'(r_fl));
    assign frame_ok  = (r_cnt < CNT_W'(MAX_BURST)) && (r_fb < r_sb) &&
                       (r_fb1 <= B_W'(r_fl));

    // Command execution and frame stepping
    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_src      = r_src;
        n_rate     = r_rate;
        n_fl       = r_fl;
        n_fb       = r_fb;
        n_fb1      = r_fb1;
        n_fb2      = r_fb2;
        n_sb       = r_sb;
        n_cnt      = r_cnt;
        n_v        = r_v;
        o_pop      = 1'b0;
        load       = 1'b0;
        ld_sample  = r_v;
        ld_last    = emit_last;
        ld_status  = ST_FRAME;
        frame_emit = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_qvalid) begin
                    unique case (i_cmd.kind)
                        CMD_START: begin
                            o_pop    = 1'b1;
                            n_active = 1'b1;
                            n_src    = i_cmd.src_rate;
                            n_rate   = i_cmd.out_rate;
                            n_fl     = FL_W'(i_cmd.frame_limit);
                            n_fb     = '0;
                            n_fb1    = B_W'(i_cmd.src_rate);
                            n_fb2    = B_W'(i_cmd.src_rate) << 1;
                            n_sb     = B_W'(i_cmd.out_rate);
                        end
                        CMD_SAMPLE: begin
                            // samples after the final frame are dropped
                            o_pop = 1'b1;
                            if (r_active) begin
                                n_v     = {i_cmd.sample ^ SAMPLE_BIAS, 8'h00};
                                n_cnt   = '0;
                                n_state = B_BURST;
                            end
                        end
                        CMD_ERROR: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                load      = 1'b1;
                                ld_sample = '0;
                                ld_last   = 1'b1;
                                ld_status = i_cmd.code;
                                n_active  = 1'b0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_BURST: begin
                if (frame_ok) begin
                    if (out_free) begin
                        frame_emit = 1'b1;
                        load       = 1'b1;
                        n_fb       = r_fb1;
                        n_fb1      = r_fb2;
                        n_fb2      = r_fb2 + B_W'(r_src);
                        n_cnt      = r_cnt + 1'b1;
                        if (emit_last) begin
                            n_active = 1'b0;
                            n_sb     = r_sb + B_W'(r_rate);
                            n_state  = B_IDLE;
                        end
                    end
                end else begin
                    n_sb    = r_sb + B_W'(r_rate);
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Lump parameters, boundaries and output payload
    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_rate <= n_rate;
        r_fl   <= n_fl;
        r_fb   <= n_fb;
        r_fb1  <= n_fb1;
        r_fb2  <= n_fb2;
        r_sb   <= n_sb;
        r_cnt  <= n_cnt;
        r_v    <= n_v;
        if (load) begin
            r_osample <= ld_sample;
            r_olast   <= ld_last;
            r_ostatus <= ld_status;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_sample = r_osample;
    assign o_last   = r_olast;
    assign o_status = r_ostatus;

    // A burst only runs for a lump that is still producing frames
    a_burst_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_BURST |-> r_active)
        else $error("burst running for a finished lump");

    // Error results carry a silent sample and close the lump
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != ST_FRAME) |-> (r_olast && r_osample == 16'd0))
        else $error("malformed error result");

    // The final frame ends the lump and the burst
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_emit && emit_last) |=> (!r_active && r_state == B_IDLE))
        else $error("lump still active after final frame");

endmodule
